[rtl/quad_element_mass_matrix_defines.svh]
// assertion macros used by the top level rtl
`ifndef QUAD_ELEMENT_MASS_MATRIX_DEFINES_SVH
`define QUAD_ELEMENT_MASS_MATRIX_DEFINES_SVH

// check holds in the same cycle as the trigger
`define QEMM_ASSERT_NOW(label, clk, rst, trig, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (check)) \
      else $error(msg);

// check holds in the cycle after the trigger
`define QEMM_ASSERT_NEXT(label, clk, rst, trig, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (check)) \
      else $error(msg);

`endif

[rtl/qemm_pkg.sv]
package qemm_pkg;

   // configuration register indexes
   localparam logic [0:0] CSR_DENSITY      = 1'b0;
   localparam logic [0:0] CSR_GAUSS_POINTS = 1'b1;

   localparam logic [31:0] DENSITY_RESET = 32'd65536;
   localparam logic [2:0]  GAUSS_RESET   = 3'd4;

   // 1/sqrt(3), q0.32
   localparam logic [31:0] G_Q32 = 32'd2479700525;

   // shape function values at a gauss point, q0.32
   localparam logic [63:0] N_HI  = 64'd2671506028;
   localparam logic [63:0] N_MID = 64'd715827883;
   localparam logic [63:0] N_LO  = 64'd191805503;

   localparam logic [63:0] HALF32 = 64'h0000_0000_8000_0000;

   // pair weights, rounded products of two shape values
   localparam logic [63:0] W_HH = (N_HI * N_HI + HALF32) >> 32;
   localparam logic [63:0] W_HM = (N_HI * N_MID + HALF32) >> 32;
   localparam logic [63:0] W_HL = (N_HI * N_LO + HALF32) >> 32;
   localparam logic [63:0] W_MM = (N_MID * N_MID + HALF32) >> 32;
   localparam logic [63:0] W_ML = (N_MID * N_LO + HALF32) >> 32;
   localparam logic [63:0] W_LL = (N_LO * N_LO + HALF32) >> 32;

   typedef enum logic [1:0] {
      SHAPE_HI,
      SHAPE_MID,
      SHAPE_LO
   } shape_type;

   typedef struct packed {
      logic jq_load;
      logic stream_load;
      logic en;
   } lane_ctrl_type;

   function automatic shape_type qemm_shape(input logic [1:0] node, input logic [1:0] pt);
      logic px;
      logic py;
      px = (node[0] ^ node[1]) == (pt[0] ^ pt[1]);
      py = node[1] == pt[1];
      if (px && py) begin
         return SHAPE_HI;
      end else if (!px && !py) begin
         return SHAPE_LO;
      end
      return SHAPE_MID;
   endfunction

   function automatic logic [31:0] qemm_weight(input logic [1:0] a, input logic [1:0] b,
                                               input logic [1:0] pt);
      shape_type sa;
      shape_type sb;
      logic [63:0] w;
      sa = qemm_shape(a, pt);
      sb = qemm_shape(b, pt);
      w = W_MM;
      if (sa == SHAPE_HI && sb == SHAPE_HI) begin
         w = W_HH;
      end else if (sa == SHAPE_LO && sb == SHAPE_LO) begin
         w = W_LL;
      end else if ((sa == SHAPE_HI && sb == SHAPE_LO) || (sa == SHAPE_LO && sb == SHAPE_HI)) begin
         w = W_HL;
      end else if (sa == SHAPE_HI || sb == SHAPE_HI) begin
         w = W_HM;
      end else if (sa == SHAPE_LO || sb == SHAPE_LO) begin
         w = W_ML;
      end
      return w[31:0];
   endfunction

endpackage

[rtl/quad_element_mass_matrix.sv]
// path: front end pipeline, lane multipliers, merge and density multiply, then the output word register
// throughput: one matrix entry per cycle on the single result port unless rsp_stall holds it, 64 entries per element
// the next element is taken while the current one streams, so entries run back to back
// reset: synchronous, clears all handshake and sequencing state, density to 1.0,
// gauss point count to 4; no clearing pass
module quad_element_mass_matrix
   import qemm_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   // element channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_x_node1,
   input  logic signed [COORD_WIDTH-1:0] req_x_node2,
   input  logic signed [COORD_WIDTH-1:0] req_x_node3,
   input  logic signed [COORD_WIDTH-1:0] req_x_node4,
   input  logic signed [COORD_WIDTH-1:0] req_y_node1,
   input  logic signed [COORD_WIDTH-1:0] req_y_node2,
   input  logic signed [COORD_WIDTH-1:0] req_y_node3,
   input  logic signed [COORD_WIDTH-1:0] req_y_node4,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_row_index,
   output logic [2:0]                    rsp_col_index,
   output logic signed [63:0]            rsp_mass_value,
   output logic                          rsp_last_entry,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [31:0]                   csr_wdata
);

`include "quad_element_mass_matrix_defines.svh"

   localparam int SW  = COORD_WIDTH + 2;
   localparam int PW  = 2 * SW;
   localparam int DW  = 2 * SW + 1;
   localparam int PRW = 2 * COORD_WIDTH + 35;
   localparam int FRONT_DEPTH = 7;
   localparam int META_DEPTH  = 5;

   typedef struct packed {
      logic       valid;
      logic [2:0] row;
      logic [2:0] col;
      logic       last;
   } meta_type;

   // configuration registers
   logic [31:0] density_ff;
   logic [2:0]  gauss_ff;

   // front end: element geometry to determinant terms
   logic [FRONT_DEPTH-1:0]       fv_ff;
   logic signed [COORD_WIDTH-1:0] x_ff [4];
   logic signed [COORD_WIDTH-1:0] y_ff [4];
   logic signed [SW-1:0]  ex_ff, fx_ff, hx_ff, ey_ff, fy_ff, hy_ff;
   logic signed [PW-1:0]  p_exfy_ff, p_fxey_ff, p_exhy_ff, p_hxey_ff, p_hxfy_ff, p_fxhy_ff;
   logic signed [DW-1:0]  d0_ff, d1_ff, d2_ff;
   logic                  pend_ff;
   logic                  req_accept;

   // entry stream
   logic                  run_ff;
   logic [5:0]            cnt_ff;
   logic                  en;
   logic                  load;
   logic [2:0]            npts;
   logic [31:0]           w_sel [4];
   logic signed [PRW-1:0] prod [4];
   lane_ctrl_type         lane_ctrl;
   meta_type              meta_in;
   meta_type              meta_ff [META_DEPTH];
   logic [63:0]           mass;

   // output word register
   logic                  rsp_valid_ff;
   logic [2:0]            row_ff;
   logic [2:0]            col_ff;
   logic [63:0]           value_ff;
   logic                  last_ff;

   assign csr_ready  = 1'b1;
   assign req_stall  = (|fv_ff) || pend_ff;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff <= DENSITY_RESET;
         gauss_ff   <= GAUSS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DENSITY:      density_ff <= csr_wdata;
            CSR_GAUSS_POINTS: gauss_ff   <= csr_wdata[2:0];
            default:          density_ff <= density_ff;
         endcase
      end
   end

   // front end pipeline; one element in flight, result parked in the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff   <= '0;
         pend_ff <= 1'b0;
      end else begin
         fv_ff <= {fv_ff[FRONT_DEPTH-2:0], req_accept};
         if (fv_ff[FRONT_DEPTH-1]) begin
            pend_ff <= 1'b1;
         end else if (load) begin
            pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff[0] <= req_x_node1;
         x_ff[1] <= req_x_node2;
         x_ff[2] <= req_x_node3;
         x_ff[3] <= req_x_node4;
         y_ff[0] <= req_y_node1;
         y_ff[1] <= req_y_node2;
         y_ff[2] <= req_y_node3;
         y_ff[3] <= req_y_node4;
      end
      // edge sums of the corner coordinates
      ex_ff <= SW'(x_ff[1]) - SW'(x_ff[0]) + SW'(x_ff[2]) - SW'(x_ff[3]);
      fx_ff <= SW'(x_ff[3]) - SW'(x_ff[0]) + SW'(x_ff[2]) - SW'(x_ff[1]);
      hx_ff <= SW'(x_ff[0]) - SW'(x_ff[1]) + SW'(x_ff[2]) - SW'(x_ff[3]);
      ey_ff <= SW'(y_ff[1]) - SW'(y_ff[0]) + SW'(y_ff[2]) - SW'(y_ff[3]);
      fy_ff <= SW'(y_ff[3]) - SW'(y_ff[0]) + SW'(y_ff[2]) - SW'(y_ff[1]);
      hy_ff <= SW'(y_ff[0]) - SW'(y_ff[1]) + SW'(y_ff[2]) - SW'(y_ff[3]);
      // cross products
      p_exfy_ff <= PW'(ex_ff) * PW'(fy_ff);
      p_fxey_ff <= PW'(fx_ff) * PW'(ey_ff);
      p_exhy_ff <= PW'(ex_ff) * PW'(hy_ff);
      p_hxey_ff <= PW'(hx_ff) * PW'(ey_ff);
      p_hxfy_ff <= PW'(hx_ff) * PW'(fy_ff);
      p_fxhy_ff <= PW'(fx_ff) * PW'(hy_ff);
      // 16 det j = d0 + xi d1 + eta d2
      d0_ff <= DW'(p_exfy_ff) - DW'(p_fxey_ff);
      d1_ff <= DW'(p_exhy_ff) - DW'(p_hxey_ff);
      d2_ff <= DW'(p_hxfy_ff) - DW'(p_fxhy_ff);
   end

   // stream sequencer, advances whenever the output word register can move
   assign en   = !rsp_valid_ff || !rsp_stall;
   assign load = en && pend_ff && (!run_ff || cnt_ff == 6'd63);
   assign npts = (gauss_ff > 3'd4) ? 3'd4 : gauss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (en) begin
         if (load) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // weight per lane: node pair from the row and column, zero past the point count
   always_comb begin
      for (int p = 0; p < 4; p++) begin
         w_sel[p] = (3'(p) < npts) ? qemm_weight(cnt_ff[5:4], cnt_ff[2:1], 2'(p)) : '0;
      end
   end

   assign lane_ctrl.jq_load     = fv_ff[FRONT_DEPTH-1];
   assign lane_ctrl.stream_load = load;
   assign lane_ctrl.en          = en;

   for (genvar g = 0; g < 4; g++) begin : g_lane
      qemm_lane #(.COORD_WIDTH(COORD_WIDTH), .LANE(g)) u_lane (
         .clock (clock),
         .ctrl  (lane_ctrl),
         .d0    (d0_ff),
         .d1    (d1_ff),
         .d2    (d2_ff),
         .w     (w_sel[g]),
         .prod  (prod[g])
      );
   end

   qemm_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
      .clock   (clock),
      .en      (en),
      .prod    (prod),
      .density (density_ff),
      .mass    (mass)
   );

   // row, column and last flag ride alongside the arithmetic
   assign meta_in.valid = run_ff;
   assign meta_in.row   = cnt_ff[5:3];
   assign meta_in.col   = cnt_ff[2:0];
   assign meta_in.last  = cnt_ff == 6'd63;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < META_DEPTH; i++) begin
            meta_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         meta_ff[0] <= meta_in;
         for (int i = 1; i < META_DEPTH; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
         rsp_valid_ff <= meta_ff[META_DEPTH-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff   <= meta_ff[META_DEPTH-1].row;
         col_ff   <= meta_ff[META_DEPTH-1].col;
         last_ff  <= meta_ff[META_DEPTH-1].last;
         // x against y degrees of freedom never couple
         value_ff <= (meta_ff[META_DEPTH-1].row[0] ^ meta_ff[META_DEPTH-1].col[0]) ?
                     64'd0 : mass;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_col_index  = col_ff;
   assign rsp_mass_value = value_ff;
   assign rsp_last_entry = last_ff;

   `QEMM_ASSERT_NOW(a_last_corner, clock, reset, rsp_valid && rsp_last_entry,
      rsp_row_index == 3'd7 && rsp_col_index == 3'd7, "last word not at row 7 column 7")
   `QEMM_ASSERT_NOW(a_mixed_zero, clock, reset,
      rsp_valid && (rsp_row_index[0] != rsp_col_index[0]),
      rsp_mass_value == 64'sd0, "mixed parity word not zero")
   `QEMM_ASSERT_NOW(a_load_gap, clock, reset, load,
      !run_ff || cnt_ff == 6'd63, "stream reloaded mid element")
   `QEMM_ASSERT_NEXT(a_front_park, clock, reset, fv_ff[FRONT_DEPTH-1],
      pend_ff || run_ff, "front end result lost")

endmodule

[rtl/qemm_wmul.sv]
module qemm_wmul
   import qemm_pkg::*;
#(
   parameter int A_WIDTH = 64
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [A_WIDTH-1:0]   a,
   input  logic        [31:0]          b,
   output logic signed [A_WIDTH+31:0]  p
);

   localparam int NL = (A_WIDTH + 31) / 32;
   localparam int EW = NL * 32;
   localparam int PW = A_WIDTH + 32;

   logic signed [EW-1:0] a_ext;
   logic signed [65:0]   pp_in [NL];
   logic signed [65:0]   pp_ff [NL];
   logic signed [PW-1:0] p_in;
   logic signed [PW-1:0] p_ff;

   assign a_ext = EW'(a);

   // one 33x33 partial product per 32 bit limb
   always_comb begin
      logic [31:0]        limb;
      logic signed [32:0] s33;
      for (int i = 0; i < NL; i++) begin
         limb = a_ext[i*32 +: 32];
         s33  = (i == NL - 1) ? $signed({limb[31], limb}) : $signed({1'b0, limb});
         pp_in[i] = s33 * $signed({1'b0, b});
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < NL; i++) begin
         p_in = p_in + (PW'(pp_ff[i]) <<< (32 * i));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff <= pp_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

[rtl/qemm_lane.sv]
module qemm_lane
   import qemm_pkg::*;
#(
   parameter int COORD_WIDTH = 24,
   parameter int LANE        = 0
) (
   input  logic                                clock,
   input  lane_ctrl_type                       ctrl,
   input  logic signed [2*COORD_WIDTH+4:0]     d0,
   input  logic signed [2*COORD_WIDTH+4:0]     d1,
   input  logic signed [2*COORD_WIDTH+4:0]     d2,
   input  logic        [31:0]                  w,
   output logic signed [2*COORD_WIDTH+34:0]    prod
);

   localparam int SW   = COORD_WIDTH + 2;
   localparam int DW   = 2 * SW + 1;
   localparam int SUMW = DW + 1;
   localparam int NUMW = SUMW + 33;
   localparam int JW   = NUMW - 36;
   localparam logic [1:0] LID = LANE[1:0];
   localparam logic XI_POS  = LID[0] ^ LID[1];
   localparam logic ETA_POS = LID[1];

   logic signed [SUMW-1:0]    t1;
   logic signed [SUMW-1:0]    t2;
   logic signed [SUMW-1:0]    sum_ff;
   logic signed [DW-1:0]      d0_s_ff;
   logic signed [DW-1:0]      d0_m1_ff;
   logic signed [DW-1:0]      d0_m2_ff;
   logic signed [SUMW+31:0]   gprod;
   logic signed [NUMW-1:0]    num;
   logic signed [JW-1:0]      jq_ff;
   logic signed [JW-1:0]      jq_cur_ff;

   assign t1 = XI_POS  ? SUMW'(d1) : -SUMW'(d1);
   assign t2 = ETA_POS ? SUMW'(d2) : -SUMW'(d2);

   // jacobian determinant at this point, rounded to q.24
   always_ff @(posedge clock) begin
      sum_ff   <= t1 + t2;
      d0_s_ff  <= d0;
      d0_m1_ff <= d0_s_ff;
      d0_m2_ff <= d0_m1_ff;
      if (ctrl.jq_load) begin
         jq_ff <= num[NUMW-1:36];
      end
      if (ctrl.stream_load) begin
         jq_cur_ff <= jq_ff;
      end
   end

   qemm_wmul #(.A_WIDTH(SUMW)) u_gmul (
      .clock (clock),
      .en    (1'b1),
      .a     (sum_ff),
      .b     (G_Q32),
      .p     (gprod)
   );

   assign num = (NUMW'(d0_m2_ff) <<< 32) + NUMW'(gprod) + (NUMW'(1) <<< 35);

   qemm_wmul #(.A_WIDTH(JW)) u_wmul (
      .clock (clock),
      .en    (ctrl.en),
      .a     (jq_cur_ff),
      .b     (w),
      .p     (prod)
   );

endmodule

[rtl/qemm_merge.sv]
module qemm_merge
   import qemm_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [2*COORD_WIDTH+34:0]  prod [4],
   input  logic        [31:0]                density,
   output logic        [63:0]                mass
);

   localparam int PRW = 2 * COORD_WIDTH + 35;
   localparam int ACW = PRW + 3;
   localparam int AW  = ACW - 24;
   localparam int DPW = AW + 32;
   localparam int MW0 = DPW + 1 - 16;
   // at least one bit above the q32.32 sign so the range check always has a slice
   localparam int MW  = (MW0 > 65) ? MW0 : 65;

   logic signed [ACW-1:0] acc;
   logic signed [AW-1:0]  a_ff;
   logic signed [DPW-1:0] dprod;
   logic signed [DPW:0]   rnd;
   logic signed [MW-1:0]  m;

   always_comb begin
      acc = ACW'(1) <<< 23;
      for (int i = 0; i < 4; i++) begin
         acc = acc + ACW'(prod[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= acc[ACW-1:24];
      end
   end

   qemm_wmul #(.A_WIDTH(AW)) u_dmul (
      .clock (clock),
      .en    (en),
      .a     (a_ff),
      .b     (density),
      .p     (dprod)
   );

   assign rnd = (DPW+1)'(dprod) + ((DPW+1)'(1) <<< 15);
   assign m   = MW'(rnd >>> 16);

   // saturate to q32.32
   always_comb begin
      if (m[MW-1:63] == {(MW-63){m[63]}}) begin
         mass = m[63:0];
      end else if (m[MW-1]) begin
         mass = 64'h8000_0000_0000_0000;
      end else begin
         mass = 64'h7FFF_FFFF_FFFF_FFFF;
      end
   end

endmodule
